### design/ccpd_pkg.sv
// Shared constants, payload types and control structs of the complex correlator.
package ccpd_pkg;

  // Window length and the width each complex part is taken at.
  localparam int TAP_COUNT = 256;
  localparam int PART_BITS = 16;

  // Widths that follow from the two constants above.
  localparam int ADDR_W    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int FILL_W    = $clog2(TAP_COUNT + 1);
  localparam int PROD_W    = 2 * PART_BITS;
  localparam int ACC_W     = PROD_W + 1 + ADDR_W;
  localparam int MAG_IN_W  = (ACC_W > 32) ? ACC_W : 33;
  localparam int SQ_W      = 64;
  localparam int COUNT_W   = 32;

  // Fixed widths of the interface fields.
  localparam int FIELD_W   = 16;
  localparam int CIDX_W    = 8;

  // Threshold after reset.
  localparam logic [SQ_W-1:0] THRESHOLD_RESET = 64'd1000000000000000;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  // One input word.
  typedef struct packed {
    logic                      cmd;
    logic signed [FIELD_W-1:0] sample_real;
    logic signed [FIELD_W-1:0] sample_imag;
    logic        [CIDX_W-1:0]  coeff_index;
    logic signed [FIELD_W-1:0] coeff_real;
    logic signed [FIELD_W-1:0] coeff_imag;
  } ccpd_in_t;

  // One result word.
  typedef struct packed {
    logic [SQ_W-1:0]    magnitude_sq;
    logic               detected;
    logic [COUNT_W-1:0] sample_number;
  } ccpd_out_t;

  // One complex value as stored in the tap memories.
  typedef struct packed {
    logic signed [PART_BITS-1:0] re;
    logic signed [PART_BITS-1:0] im;
  } ccpd_cplx_t;

  // Control of the multiply-accumulate unit, aligned with the memory read data.
  typedef struct packed {
    logic clear;
    logic valid;
    logic live;
  } ccpd_mac_ctrl_t;

  // Result of the magnitude unit.
  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] magnitude;
    logic            detected;
  } ccpd_mag_res_t;

endpackage

### design/ccpd_tap_mem.sv
// Sample window and coefficient memories, one write and one registered read each.
module ccpd_tap_mem (
  input  logic                        clk,
  input  logic                        win_we,
  input  logic [ccpd_pkg::ADDR_W-1:0] win_waddr,
  input  ccpd_pkg::ccpd_cplx_t        win_wdata,
  input  logic [ccpd_pkg::ADDR_W-1:0] win_raddr,
  output ccpd_pkg::ccpd_cplx_t        win_rdata,
  input  logic                        coef_we,
  input  logic [ccpd_pkg::ADDR_W-1:0] coef_waddr,
  input  ccpd_pkg::ccpd_cplx_t        coef_wdata,
  input  logic [ccpd_pkg::ADDR_W-1:0] coef_raddr,
  output ccpd_pkg::ccpd_cplx_t        coef_rdata
);
  import ccpd_pkg::*;

  ccpd_cplx_t win_mem  [TAP_COUNT];
  ccpd_cplx_t coef_mem [TAP_COUNT];

  // Circular sample window.
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    win_rdata <= win_mem[win_raddr];
  end

  // Coefficient store, indexed by tap.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

endmodule

### design/ccpd_cmac.sv
// Shared complex multiply-accumulate unit: one tap per cycle.
module ccpd_cmac (
  input  logic                              clk,
  input  logic                              rst,
  input  ccpd_pkg::ccpd_mac_ctrl_t          ctrl,
  input  ccpd_pkg::ccpd_cplx_t              win_data,
  input  ccpd_pkg::ccpd_cplx_t              coef_data,
  output logic                              busy,
  output logic signed [ccpd_pkg::ACC_W-1:0] acc_re,
  output logic signed [ccpd_pkg::ACC_W-1:0] acc_im
);
  import ccpd_pkg::*;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] p_ac;
  logic signed [PROD_W-1:0] p_bd;
  logic signed [PROD_W-1:0] p_ad;
  logic signed [PROD_W-1:0] p_bc;

  // Product stage; a tap beyond the filled part of the window counts as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid && !ctrl.clear;
    end
    if (ctrl.live) begin
      p_ac <= PROD_W'(win_data.re) * PROD_W'(coef_data.re);
      p_bd <= PROD_W'(win_data.im) * PROD_W'(coef_data.im);
      p_ad <= PROD_W'(win_data.re) * PROD_W'(coef_data.im);
      p_bc <= PROD_W'(win_data.im) * PROD_W'(coef_data.re);
    end else begin
      p_ac <= '0;
      p_bd <= '0;
      p_ad <= '0;
      p_bc <= '0;
    end
  end

  // Accumulate stage: (a + ib)(c + id) = (ac - bd) + i(ad + bc).
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (prod_valid) begin
      acc_re <= acc_re + ACC_W'(p_ac) - ACC_W'(p_bd);
      acc_im <= acc_im + ACC_W'(p_ad) + ACC_W'(p_bc);
    end
  end

  assign busy = prod_valid;

endmodule

### design/ccpd_mag.sv
// Squared magnitude with saturation and threshold compare, one multiplier reused twice.
module ccpd_mag (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [ccpd_pkg::MAG_IN_W-1:0] acc_re,
  input  logic signed [ccpd_pkg::MAG_IN_W-1:0] acc_im,
  input  logic        [ccpd_pkg::SQ_W-1:0]     threshold,
  output ccpd_pkg::ccpd_mag_res_t              res
);
  import ccpd_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_ABS  = 7'b0000010,
    M_SQRE = 7'b0000100,
    M_SQIM = 7'b0001000,
    M_SUM  = 7'b0010000,
    M_CMP  = 7'b0100000,
    M_DONE = 7'b1000000
  } mag_state_t;

  mag_state_t            state;
  mag_state_t            state_next;
  logic [MAG_IN_W-1:0]   abs_re;
  logic [MAG_IN_W-1:0]   abs_im;
  logic [SQ_W-1:0]       sq_re;
  logic [SQ_W-1:0]       sq_im;
  logic [SQ_W-1:0]       magnitude;
  logic                  detected;
  logic [31:0]           mul_op;
  logic                  mul_ovf;
  logic [SQ_W-1:0]       mul_out;
  logic [SQ_W:0]         sum;

  // Sequencer through the steps of one magnitude.
  always_comb begin
    state_next = state;
    unique case (state)
      M_IDLE:  if (start) state_next = M_ABS;
      M_ABS:   state_next = M_SQRE;
      M_SQRE:  state_next = M_SQIM;
      M_SQIM:  state_next = M_SUM;
      M_SUM:   state_next = M_CMP;
      M_CMP:   state_next = M_DONE;
      M_DONE:  state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared squarer: a magnitude above 32 bits squares past 64 bits and saturates.
  always_comb begin
    if (state == M_SQIM) begin
      mul_op  = abs_im[31:0];
      mul_ovf = |abs_im[MAG_IN_W-1:32];
    end else begin
      mul_op  = abs_re[31:0];
      mul_ovf = |abs_re[MAG_IN_W-1:32];
    end
    mul_out = SQ_W'(mul_op) * SQ_W'(mul_op);
    sum     = {1'b0, sq_re} + {1'b0, sq_im};
  end

  // Datapath registers, one step per state.
  always_ff @(posedge clk) begin
    if (state == M_ABS) begin
      abs_re <= acc_re[MAG_IN_W-1] ? MAG_IN_W'(-acc_re) : MAG_IN_W'(acc_re);
      abs_im <= acc_im[MAG_IN_W-1] ? MAG_IN_W'(-acc_im) : MAG_IN_W'(acc_im);
    end
    if (state == M_SQRE) begin
      sq_re <= mul_ovf ? '1 : mul_out;
    end
    if (state == M_SQIM) begin
      sq_im <= mul_ovf ? '1 : mul_out;
    end
    if (state == M_SUM) begin
      magnitude <= sum[SQ_W] ? '1 : sum[SQ_W-1:0];
    end
    if (state == M_CMP) begin
      detected <= (magnitude >= threshold);
    end
  end

  assign res.done      = (state == M_DONE);
  assign res.magnitude = magnitude;
  assign res.detected  = detected;

endmodule

### design/complex_correlator_peak_detect_unit.sv
// Top level of the sliding-window complex correlator with peak detection.
//
// Input words arrive on in_valid/in_ready with payload in_word. A word with
// cmd set writes one complex coefficient (taps at or beyond the window length
// are ignored) and gives no result. A sample word shifts into the window,
// newest at tap 0, and produces exactly one result word on out_valid/out_ready:
// the squared magnitude of the correlation sum, saturated to 64 bits, the
// detect flag and the running sample number. From accept to a valid result,
// one shared complex multiply-accumulate reads one tap per cycle from the
// window and coefficient memories, its read and product registers drain, then
// a shared squarer forms the magnitude in six steps. in_ready is high only
// between samples, so no new word is taken before the previous sample's
// result is loaded. The result sits in an output register; while it waits,
// coefficient words and the next sample are still taken, and a following
// result waits until the receiver has taken the previous one.
// cfg_wen writes cfg_wdata to the detect threshold; write it only while idle.
// Synchronous reset empties the window, zeroes the sample count, restores the
// threshold and drops out_valid. Coefficients are undefined until written.
module complex_correlator_peak_detect_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ccpd_pkg::ccpd_in_t                    in_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ccpd_pkg::ccpd_out_t                   out_word,
  input  logic                                  cfg_wen,
  input  logic [ccpd_pkg::SQ_W-1:0]             cfg_wdata
);
  import ccpd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACCUM = 5'b00010,
    S_DRAIN = 5'b00100,
    S_MAG   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(TAP_COUNT - 1);
  localparam logic [FILL_W-1:0] FULL     = FILL_W'(TAP_COUNT);

  state_t               state;
  state_t               state_next;
  logic [ADDR_W-1:0]    wp;
  logic [ADDR_W-1:0]    walk_addr;
  logic [ADDR_W-1:0]    walk_k;
  logic [FILL_W-1:0]    fill;
  logic                 rd_valid;
  logic                 rd_live;
  logic [COUNT_W-1:0]   sample_counter;
  logic [SQ_W-1:0]      threshold;

  logic                 in_acc;
  logic                 smp_acc;
  logic                 cof_acc;
  logic                 issue;
  logic                 out_free;
  logic                 drain_done;
  logic                 load;
  logic [31:0]          cidx_wide;
  logic                 cidx_ok;

  ccpd_cplx_t           smp_wdata;
  ccpd_cplx_t           cof_wdata;
  ccpd_cplx_t           win_rdata;
  ccpd_cplx_t           coef_rdata;
  ccpd_mac_ctrl_t       mac_ctrl;
  logic                 mac_busy;
  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;
  ccpd_mag_res_t        mag_res;

  // Handshake decode and write data, parts taken at PART_BITS.
  always_comb begin
    in_ready   = (state == S_IDLE);
    in_acc     = in_valid && in_ready;
    smp_acc    = in_acc && (in_word.cmd == CMD_SAMPLE);
    cof_acc    = in_acc && (in_word.cmd == CMD_COEFF);
    issue      = (state == S_ACCUM);
    out_free   = !out_valid || out_ready;
    drain_done = (state == S_DRAIN) && !rd_valid && !mac_busy;
    load       = ((state == S_MAG && mag_res.done) || state == S_HOLD) && out_free;
    cidx_wide  = 32'(in_word.coeff_index);
    cidx_ok    = (cidx_wide < 32'(TAP_COUNT));
    smp_wdata.re = in_word.sample_real[PART_BITS-1:0];
    smp_wdata.im = in_word.sample_imag[PART_BITS-1:0];
    cof_wdata.re = in_word.coeff_real[PART_BITS-1:0];
    cof_wdata.im = in_word.coeff_imag[PART_BITS-1:0];
  end

  // Main sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (smp_acc) state_next = S_ACCUM;
      S_ACCUM: if (walk_k == LAST_TAP) state_next = S_DRAIN;
      S_DRAIN: if (drain_done) state_next = S_MAG;
      S_MAG:   if (mag_res.done) state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wp             <= '0;
      fill           <= '0;
      rd_valid       <= 1'b0;
      sample_counter <= '0;
      threshold      <= THRESHOLD_RESET;
      out_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_wen) begin
        threshold <= cfg_wdata;
      end
      if (smp_acc) begin
        wp <= (wp == LAST_TAP) ? '0 : wp + ADDR_W'(1);
        if (fill != FULL) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (load) begin
        out_valid      <= 1'b1;
        sample_counter <= sample_counter + COUNT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tap walk: window address steps back from the newest sample with wrap.
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      walk_addr <= wp;
      walk_k    <= '0;
    end else if (issue) begin
      walk_addr <= (walk_addr == '0) ? LAST_TAP : walk_addr - ADDR_W'(1);
      walk_k    <= walk_k + ADDR_W'(1);
    end
    rd_live <= issue && (FILL_W'(walk_k) < fill);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_word.magnitude_sq  <= mag_res.magnitude;
      out_word.detected      <= mag_res.detected;
      out_word.sample_number <= sample_counter;
    end
  end

  assign mac_ctrl.clear = smp_acc;
  assign mac_ctrl.valid = rd_valid;
  assign mac_ctrl.live  = rd_live;

  ccpd_tap_mem u_tap_mem (
    .clk        (clk),
    .win_we     (smp_acc),
    .win_waddr  (wp),
    .win_wdata  (smp_wdata),
    .win_raddr  (walk_addr),
    .win_rdata  (win_rdata),
    .coef_we    (cof_acc && cidx_ok),
    .coef_waddr (cidx_wide[ADDR_W-1:0]),
    .coef_wdata (cof_wdata),
    .coef_raddr (walk_k),
    .coef_rdata (coef_rdata)
  );

  ccpd_cmac u_cmac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .win_data  (win_rdata),
    .coef_data (coef_rdata),
    .busy      (mac_busy),
    .acc_re    (acc_re),
    .acc_im    (acc_im)
  );

  ccpd_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .start     (drain_done),
    .acc_re    (MAG_IN_W'(acc_re)),
    .acc_im    (MAG_IN_W'(acc_im)),
    .threshold (threshold),
    .res       (mag_res)
  );

  // A new result word appears only when a magnitude has just been finished.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_MAG || $past(state) == S_HOLD))
    else $error("result word raised outside the magnitude step");

  // A sample word starts the tap walk at tap zero.
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> (state == S_ACCUM && walk_k == '0))
    else $error("tap walk did not start at tap zero");

  // The fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("window fill count out of range");

  // The magnitude unit finishes only while the sequencer waits for it.
  a_mag_done: assert property (@(posedge clk) disable iff (rst)
    mag_res.done |-> state == S_MAG)
    else $error("magnitude finished outside its step");

endmodule

### tb/testbench.sv
// Self-checking testbench of the complex correlator with peak detection.
module testbench;
  import ccpd_pkg::*;

  // Run control constants.
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_AFTER     = 30;
  localparam int HOLD_CYCLES    = 1500;
  localparam int NARROW_TAPS    = 12;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_EVERY_FOURTH,
    READY_SPARSE
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ccpd_in_t            in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ccpd_out_t           out_word;
  logic                cfg_wen = 1'b0;
  logic [SQ_W-1:0]     cfg_wdata = '0;

  // Predictor state: window, coefficient bank, sample count and threshold.
  logic signed [PART_BITS-1:0] tap_samp_re [TAP_COUNT];
  logic signed [PART_BITS-1:0] tap_samp_im [TAP_COUNT];
  logic signed [PART_BITS-1:0] tap_coef_re [TAP_COUNT];
  logic signed [PART_BITS-1:0] tap_coef_im [TAP_COUNT];
  logic [COUNT_W-1:0]          sample_count;
  logic [SQ_W-1:0]             threshold;

  ccpd_in_t    pending_words [$];
  ccpd_out_t   predicted_peaks [$];
  ccpd_out_t   peak;

  logic        in_fire = 1'b0;
  int          idle_cycles = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  stall_mode_t stall_mode = READY_ALWAYS;

  complex_correlator_peak_detect_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Square of a correlation part, saturated to 64 bits.
  function automatic logic [SQ_W-1:0] square_sat(input longint x);
    longint unsigned a;
    a = (x < 0) ? -x : x;
    if (a > 64'hFFFF_FFFF) return '1;
    return a * a;
  endfunction

  // Applies one accepted word to the predictor; a sample queues its peak result.
  task automatic correlate_word(input ccpd_in_t w);
    longint          acc_re;
    longint          acc_im;
    longint          a, b, c, d;
    logic [SQ_W:0]   total;
    ccpd_out_t       res;
    if (w.cmd == CMD_COEFF) begin
      // Taps at or beyond the window length are ignored.
      if (int'(w.coeff_index) < TAP_COUNT) begin
        tap_coef_re[w.coeff_index] = w.coeff_real[PART_BITS-1:0];
        tap_coef_im[w.coeff_index] = w.coeff_imag[PART_BITS-1:0];
      end
    end else begin
      for (int k = TAP_COUNT - 1; k > 0; k--) begin
        tap_samp_re[k] = tap_samp_re[k-1];
        tap_samp_im[k] = tap_samp_im[k-1];
      end
      tap_samp_re[0] = w.sample_real[PART_BITS-1:0];
      tap_samp_im[0] = w.sample_imag[PART_BITS-1:0];
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        a = tap_samp_re[k];
        b = tap_samp_im[k];
        c = tap_coef_re[k];
        d = tap_coef_im[k];
        acc_re += a * c - b * d;
        acc_im += a * d + b * c;
      end
      total = {1'b0, square_sat(acc_re)} + {1'b0, square_sat(acc_im)};
      res.magnitude_sq  = total[SQ_W] ? '1 : total[SQ_W-1:0];
      res.detected      = (res.magnitude_sq >= threshold);
      res.sample_number = sample_count;
      sample_count      = sample_count + 1'b1;
      predicted_peaks.push_back(res);
    end
  endtask

  // One random complex part: mostly small values, with extremes and full range mixed in.
  function automatic logic [FIELD_W-1:0] rand_part(input bit narrow);
    int          sel;
    int          span;
    logic [31:0] raw;
    sel  = $urandom_range(0, narrow ? 63 : 7);
    span = $urandom_range(1, 10);
    raw  = $urandom_range(0, (1 << span) - 1) - (1 << (span - 1));
    case (sel)
      0: begin
        return 16'h8000;
      end
      1: begin
        return 16'h7FFF;
      end
      2: begin
        raw = $urandom();
        return raw[FIELD_W-1:0];
      end
      default: begin
        return raw[FIELD_W-1:0];
      end
    endcase
  endfunction

  // A random word; in narrow mode only the first few taps get nonzero coefficients.
  function automatic ccpd_in_t random_word(input bit narrow);
    ccpd_in_t w;
    w.cmd         = ($urandom_range(0, 9) < 4) ? CMD_COEFF : CMD_SAMPLE;
    w.sample_real = rand_part(narrow);
    w.sample_imag = rand_part(narrow);
    w.coeff_index = CIDX_W'($urandom_range(0, TAP_COUNT - 1));
    w.coeff_real  = rand_part(narrow);
    w.coeff_imag  = rand_part(narrow);
    if (narrow && w.coeff_index >= NARROW_TAPS) begin
      w.coeff_real = '0;
      w.coeff_imag = '0;
    end
    return w;
  endfunction

  task automatic push_word(input logic cmd, input logic [FIELD_W-1:0] sr,
                           input logic [FIELD_W-1:0] si, input logic [CIDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] cr, input logic [FIELD_W-1:0] ci);
    ccpd_in_t w;
    w.cmd         = cmd;
    w.sample_real = sr;
    w.sample_imag = si;
    w.coeff_index = idx;
    w.coeff_real  = cr;
    w.coeff_imag  = ci;
    pending_words.push_back(w);
  endtask

  // Waits until every word is taken and every result is back, then lets the block settle.
  // The check runs at the rising edge, where the driver's last update has settled.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || predicted_peaks.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [SQ_W-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    threshold = value;
  endtask

  // Driver: presents queued words in bursts with random gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word  <= pending_words.pop_front();
        in_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off once results flow, otherwise a changing stall pattern.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        mode_left  = $urandom_range(50, 600);
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        READY_ALWAYS: begin
          out_ready <= 1'b1;
        end
        READY_COIN: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        READY_EVERY_FOURTH: begin
          out_ready <= (mode_left % 4 == 0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 4) == 0);
        end
      endcase
    end
  end

  // Monitor: checks each result word against the oldest prediction, then predicts new words.
  always @(posedge clk) begin
    if (rst) begin
      in_fire     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (predicted_peaks.size() == 0) begin
          $display("%0t: result with none expected: magnitude_sq %0d detected %0b number %0d",
                   $time, out_word.magnitude_sq, out_word.detected, out_word.sample_number);
          mismatch_count++;
        end else begin
          peak = predicted_peaks.pop_front();
          if (out_word.magnitude_sq !== peak.magnitude_sq) begin
            $display("%0t: magnitude_sq expected %0d, actual %0d",
                     $time, peak.magnitude_sq, out_word.magnitude_sq);
            mismatch_count++;
          end
          if (out_word.detected !== peak.detected) begin
            $display("%0t: detected expected %0b, actual %0b",
                     $time, peak.detected, out_word.detected);
            mismatch_count++;
          end
          if (out_word.sample_number !== peak.sample_number) begin
            $display("%0t: sample_number expected %0d, actual %0d",
                     $time, peak.sample_number, out_word.sample_number);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        correlate_word(in_word);
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("complex_correlator_peak_detect_unit test failed");
    $finish;
  end

  // Stimulus: directed words first, then random phases under several thresholds.
  initial begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      tap_samp_re[k] = '0;
      tap_samp_im[k] = '0;
      tap_coef_re[k] = '0;
      tap_coef_im[k] = '0;
    end
    sample_count = '0;
    threshold    = THRESHOLD_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every tap gets the most negative coefficient before the first sample.
    for (int k = 0; k < TAP_COUNT; k++) begin
      push_word(CMD_COEFF, '0, '0, CIDX_W'(k), 16'h8000, 16'h8000);
    end
    // Zero sample, then full-scale samples that reach both kinds of saturation.
    push_word(CMD_SAMPLE, 16'h0000, 16'h0000, '0, '0, '0);
    repeat (4) push_word(CMD_SAMPLE, 16'h8000, 16'h0000, '0, '0, '0);
    push_word(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, '0, '0, '0);
    push_word(CMD_SAMPLE, 16'h8000, 16'h8000, '0, '0, '0);
    // Rewrites at the lowest, highest and middle taps.
    push_word(CMD_COEFF, 16'h7FFF, 16'h7FFF, 8'd0, 16'h7FFF, 16'h8000);
    push_word(CMD_COEFF, 16'h8000, 16'h8000, 8'd255, 16'hFFFF, 16'h7FFF);
    push_word(CMD_COEFF, 16'hFFFF, 16'h0001, 8'd128, 16'h0000, 16'h0000);
    push_word(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, '0, '0, '0);
    push_word(CMD_SAMPLE, 16'h7FFF, 16'h8000, '0, '0, '0);
    push_word(CMD_SAMPLE, 16'h0001, 16'h0000, 8'hFF, 16'h8000, 16'h7FFF);
    // Sample words carry coefficient fields and the reverse; both are ignored.
    push_word(CMD_SAMPLE, 16'h0000, 16'h0001, 8'hAA, 16'h7FFF, 16'h8000);
    push_word(CMD_COEFF, 16'h8000, 16'h7FFF, 8'h55, 16'h0002, 16'hFFFE);
    push_word(CMD_SAMPLE, 16'h0003, 16'hFFFD, '0, '0, '0);

    // Threshold zero: every sample is flagged.
    set_threshold('0);
    repeat (120) pending_words.push_back(random_word(1'b0));

    // Threshold at its maximum: only saturated magnitudes are flagged.
    set_threshold('1);
    repeat (120) pending_words.push_back(random_word(1'b0));

    // Sparse coefficient bank and small data, so magnitudes straddle the threshold.
    set_threshold((64'd1 << $urandom_range(20, 46)) | 64'($urandom_range(0, 1023)));
    for (int k = 0; k < TAP_COUNT; k++) begin
      push_word(CMD_COEFF, rand_part(1'b1), rand_part(1'b1), CIDX_W'(k),
                (k < NARROW_TAPS) ? rand_part(1'b1) : 16'h0000,
                (k < NARROW_TAPS) ? rand_part(1'b1) : 16'h0000);
    end
    repeat (120) pending_words.push_back(random_word(1'b1));

    // A fully random threshold.
    set_threshold({$urandom(), $urandom()});
    repeat (60) pending_words.push_back(random_word(1'b1));

    wait_drained();
    if (mismatch_count == 0 && predicted_peaks.size() == 0) begin
      $display("complex_correlator_peak_detect_unit test passed");
    end else begin
      $display("complex_correlator_peak_detect_unit test failed");
    end
    $finish;
  end

endmodule
